### design/dequ_pkg.sv
package dequ_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int HELD_W  = $clog2(DEPTH + 1);
	localparam int COUNT_W = 5;
	localparam int DATA_W  = 32;

	localparam logic [1:0] KIND_PUSH_BACK  = 2'd0;
	localparam logic [1:0] KIND_PUSH_FRONT = 2'd1;
	localparam logic [1:0] KIND_POP_BACK   = 2'd2;
	localparam logic [1:0] KIND_POP_FRONT  = 2'd3;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [DATA_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] popped;
		logic [COUNT_W-1:0]       count;
	} out_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} state_t;

endpackage

### design/dequ_ctrl.sv
module dequ_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output dequ_pkg::cmd_t  cmd
);
	import dequ_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		busy     = 1'b1;
		done     = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_RESP;
			end
			ST_RESP: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### design/dequ_dp.sv
module dequ_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  dequ_pkg::cmd_t cmd,
	input  dequ_pkg::in_t  req,
	output dequ_pkg::out_t rsp
);
	import dequ_pkg::*;

	in_t                 item_q;
	logic [IDX_W-1:0]    front_q;
	logic [IDX_W-1:0]    back_q;
	logic [HELD_W-1:0]   held_q;
	logic [1:0]          status_q;
	logic                pop_ok_q;
	logic [DATA_W-1:0]   rd_q;
	logic [DATA_W-1:0]   mem [DEPTH];

	logic                full;
	logic                empty;
	logic [IDX_W-1:0]    front_inc;
	logic [IDX_W-1:0]    front_dec;
	logic [IDX_W-1:0]    back_inc;
	logic [IDX_W-1:0]    back_dec;
	logic [IDX_W-1:0]    front_d;
	logic [IDX_W-1:0]    back_d;
	logic [HELD_W-1:0]   held_d;
	logic [1:0]          status_d;
	logic                pop_ok_d;
	logic                wr_en;
	logic                rd_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [IDX_W-1:0]    rd_addr;

	assign full  = (held_q == HELD_W'(DEPTH));
	assign empty = (held_q == '0);

	assign front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
	assign back_inc  = (back_q == IDX_W'(DEPTH - 1)) ? '0 : back_q + 1'b1;
	assign back_dec  = (back_q == '0) ? IDX_W'(DEPTH - 1) : back_q - 1'b1;

	always_comb begin
		front_d  = front_q;
		back_d   = back_q;
		held_d   = held_q;
		status_d = STATUS_DONE;
		pop_ok_d = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		wr_addr  = back_q;
		rd_addr  = front_q;
		unique case (item_q.kind)
			KIND_PUSH_BACK: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = back_q;
					back_d  = back_inc;
					held_d  = held_q + 1'b1;
				end
			end
			KIND_PUSH_FRONT: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = front_dec;
					front_d = front_dec;
					held_d  = held_q + 1'b1;
				end
			end
			KIND_POP_BACK: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					rd_en    = 1'b1;
					pop_ok_d = 1'b1;
					rd_addr  = back_dec;
					back_d   = back_dec;
					held_d   = held_q - 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					rd_en    = 1'b1;
					pop_ok_d = 1'b1;
					rd_addr  = front_q;
					front_d  = front_inc;
					held_d   = held_q - 1'b1;
				end
			end
			default: begin
				status_d = STATUS_DONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			back_q   <= '0;
			held_q   <= '0;
			status_q <= STATUS_DONE;
			pop_ok_q <= 1'b0;
		end else if (cmd.exec) begin
			front_q  <= front_d;
			back_q   <= back_d;
			held_q   <= held_d;
			status_q <= status_d;
			pop_ok_q <= pop_ok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[wr_addr] <= item_q.value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rsp.status = status_q;
	assign rsp.popped = pop_ok_q ? rd_q : '0;
	assign rsp.count  = COUNT_W'(held_q);

endmodule

### design/double_ended_queue_core.sv
// Each transaction runs through the states idle (acceptance), exec (the index update
// and at most one store access) and resp (the result on rsp and done high).
// A new transaction is accepted only once the controller is back in the idle state;
// the read of the store is registered; busy is low only in the idle state.
// Reset clears both indices and the count; store contents stay undefined until pushed.
module double_ended_queue_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  dequ_pkg::in_t  req,
	output logic           done,
	output dequ_pkg::out_t rsp
);
	import dequ_pkg::*;

	cmd_t cmd;

	dequ_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	dequ_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

### test/double_ended_queue_core_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_core_tb;
	import dequ_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_OPS  = 1800;
	localparam int PLAN_ROWS   = 17;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [DATA_W-1:0] value;
		int                       reps;
		bit                       typed;
		logic [1:0]               status;
		logic signed [DATA_W-1:0] popped;
		logic [COUNT_W-1:0]       count;
	} plan_row_t;

	// Rows with typed set carry the result by hand; the others use the deque mirror.
	localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
		'{KIND_POP_BACK,   32'sh0000_0000,  1, 1'b1, STATUS_EMPTY, 32'sh0000_0000, 5'd0},
		'{KIND_POP_FRONT,  32'sh0000_0000,  1, 1'b1, STATUS_EMPTY, 32'sh0000_0000, 5'd0},
		'{KIND_PUSH_BACK,  32'sh7FFF_FFFF,  1, 1'b1, STATUS_DONE,  32'sh0000_0000, 5'd1},
		'{KIND_PUSH_FRONT, 32'sh8000_0000,  1, 1'b1, STATUS_DONE,  32'sh0000_0000, 5'd2},
		'{KIND_POP_BACK,   32'sh0000_0000,  1, 1'b1, STATUS_DONE,  32'sh7FFF_FFFF, 5'd1},
		'{KIND_POP_FRONT,  32'sh0000_0000,  1, 1'b1, STATUS_DONE,  32'sh8000_0000, 5'd0},
		'{KIND_PUSH_FRONT, 32'shFFFF_FFFF,  1, 1'b1, STATUS_DONE,  32'sh0000_0000, 5'd1},
		'{KIND_POP_BACK,   32'sh0000_0000,  1, 1'b1, STATUS_DONE,  32'shFFFF_FFFF, 5'd0},
		'{KIND_POP_FRONT,  32'sh0000_0000,  1, 1'b1, STATUS_EMPTY, 32'sh0000_0000, 5'd0},
		'{KIND_PUSH_FRONT, 32'sh5555_5555,  8, 1'b0, STATUS_DONE,  32'sh0000_0000, 5'd0},
		'{KIND_PUSH_BACK,  32'shAAAA_AAAA,  8, 1'b0, STATUS_DONE,  32'sh0000_0000, 5'd0},
		'{KIND_PUSH_BACK,  32'sh0000_0001,  1, 1'b1, STATUS_FULL,  32'sh0000_0000, 5'd16},
		'{KIND_PUSH_FRONT, 32'sh0000_0002,  1, 1'b1, STATUS_FULL,  32'sh0000_0000, 5'd16},
		'{KIND_POP_BACK,   32'sh0000_0000,  1, 1'b0, STATUS_DONE,  32'sh0000_0000, 5'd0},
		'{KIND_PUSH_FRONT, 32'sh0000_0003,  1, 1'b0, STATUS_DONE,  32'sh0000_0000, 5'd0},
		'{KIND_POP_FRONT,  32'sh0000_0000, 16, 1'b0, STATUS_DONE,  32'sh0000_0000, 5'd0},
		'{KIND_POP_BACK,   32'sh1234_5678,  1, 1'b1, STATUS_EMPTY, 32'sh0000_0000, 5'd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	in_t  req = '0;
	out_t rsp;

	out_t answers_due [$];
	int   mismatches = 0;
	int   stalled_cycles = 0;
	int   burst_left = 0;

	logic signed [DATA_W-1:0] slots [DEPTH];
	int unsigned front_slot = 0;
	int unsigned back_slot = 0;
	int unsigned fill = 0;

	double_ended_queue_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic out_t deque_op_result(in_t op);
		out_t r;
		r.status = STATUS_DONE;
		r.popped = '0;
		if (op.kind == KIND_PUSH_BACK || op.kind == KIND_PUSH_FRONT) begin
			if (fill >= DEPTH) begin
				r.status = STATUS_FULL;
			end else if (op.kind == KIND_PUSH_BACK) begin
				slots[back_slot] = op.value;
				back_slot = (back_slot + 1) % DEPTH;
				fill++;
			end else begin
				front_slot = (front_slot + DEPTH - 1) % DEPTH;
				slots[front_slot] = op.value;
				fill++;
			end
		end else begin
			if (fill == 0) begin
				r.status = STATUS_EMPTY;
			end else if (op.kind == KIND_POP_BACK) begin
				back_slot = (back_slot + DEPTH - 1) % DEPTH;
				r.popped = slots[back_slot];
				fill--;
			end else begin
				r.popped = slots[front_slot];
				front_slot = (front_slot + 1) % DEPTH;
				fill--;
			end
		end
		r.count = COUNT_W'(fill);
		return r;
	endfunction

	// The sender works in bursts; a new burst starts after a random gap.
	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		burst_left = ($urandom_range(3) == 0) ? $urandom_range(200, 80) : $urandom_range(30, 1);
		return $urandom_range(12, 1);
	endfunction

	task automatic issue(input in_t op, input int gap, input bit typed, input out_t want);
		out_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= op;
		do @(posedge clk); while (busy);
		predicted = deque_op_result(op);
		answers_due.push_back(typed ? want : predicted);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return '0;
			3:       return -1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		in_t  op;
		out_t want;
		int   gap;
		int   push_pct;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < PLAN_ROWS; r++) begin
			for (int k = 0; k < PLAN[r].reps; k++) begin
				op.kind = PLAN[r].kind;
				op.value = PLAN[r].value;
				want.status = PLAN[r].status;
				want.popped = PLAN[r].popped;
				want.count = PLAN[r].count;
				issue(op, next_gap(), PLAN[r].typed, want);
			end
		end
		drain();

		push_pct = 50;
		for (int i = 0; i < RANDOM_OPS; i++) begin
			gap = next_gap();
			if (gap != 0) begin
				case ($urandom_range(2))
					0:       push_pct = 15;
					1:       push_pct = 50;
					default: push_pct = 85;
				endcase
			end
			if ($urandom_range(99) < push_pct)
				op.kind = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
			else
				op.kind = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
			op.value = pick_value();
			issue(op, gap, 1'b0, '0);
			if (i == RANDOM_OPS / 2 || $urandom_range(399) == 0)
				drain();
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (done) begin
				if (answers_due.size() == 0) begin
					$error("result with no transaction pending: status %0d popped %0d count %0d",
						rsp.status, rsp.popped, rsp.count);
					mismatches++;
				end else begin
					want = answers_due[0];
					answers_due.delete(0);
					if (rsp.status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, rsp.status);
						mismatches++;
					end
					if (rsp.popped !== want.popped) begin
						$error("popped expected %0d actual %0d", want.popped, rsp.popped);
						mismatches++;
					end
					if (rsp.count !== want.count) begin
						$error("count expected %0d actual %0d", want.count, rsp.count);
						mismatches++;
					end
				end
			end
			if ((start && !busy) || done)
				stalled_cycles = 0;
			else
				stalled_cycles++;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule

### sim.f
design/dequ_pkg.sv
design/dequ_ctrl.sv
design/dequ_dp.sv
design/double_ended_queue_core.sv
test/double_ended_queue_core_tb.sv
